FILE: rtl/arp_cache_lru_ttl_assert.svh
// Assertion macros used by the checker file.
`ifndef ARP_CACHE_LRU_TTL_ASSERT_SVH
`define ARP_CACHE_LRU_TTL_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/arpc_pkg.sv
package arpc_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned IP_W        = 32;
    localparam int unsigned MAC_W       = 48;
    localparam int unsigned TICK_W      = 64;
    localparam int unsigned TTL_W       = 32;

    localparam logic [TTL_W-1:0] TTL_RESET = 32'd300000;

    localparam logic FUNC_LEARN  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE
    } arpc_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture the input word, bump the tick, restart the scan
        logic issue;   // read the entry at the scan index and advance
        logic commit;  // update the table on a learn and load the result register
    } arpc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;  // scan index sits on the last entry
        logic out_busy;   // result register holds a word that is not taken
    } arpc_sts_t;

endpackage

FILE: rtl/arpc_ctrl.sv
module arpc_ctrl import arpc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  arpc_sts_t sts,
    output arpc_cmd_t cmd
);

    arpc_state_t state_reg;
    arpc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (!sts.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_RESOLVE: begin
                // hold the result until the output register can take it
                cmd.commit = !sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/arpc_dp.sv
module arpc_dp import arpc_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_func,
    input  logic [IP_W-1:0]  s_ip_addr,
    input  logic [MAC_W-1:0] s_mac_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_hit,
    output logic [MAC_W-1:0] m_mac_out,
    input  logic             cfg_wr_en,
    input  logic [TTL_W-1:0] cfg_wr_data,
    input  arpc_cmd_t        cmd,
    output arpc_sts_t        sts
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    // Table storage
    logic [IP_W-1:0]   ip_mem    [ENTRIES];
    logic [MAC_W-1:0]  mac_mem   [ENTRIES];
    logic [TICK_W-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic [TTL_W-1:0]  ttl_reg;
    logic [TICK_W-1:0] tick_reg;

    // Current word
    logic              func_reg;
    logic [IP_W-1:0]   key_ip_reg;
    logic [MAC_W-1:0]  key_mac_reg;

    // Scan
    logic [IDX_W-1:0]  idx_reg;
    logic              eval_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [IP_W-1:0]   rd_ip_reg;
    logic [MAC_W-1:0]  rd_mac_reg;
    logic [TICK_W-1:0] rd_stamp_reg;

    // Trackers
    logic              match_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [MAC_W-1:0]  match_mac_reg;
    logic [TICK_W-1:0] age_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              min_seen_reg;
    logic [IDX_W-1:0]  min_idx_reg;
    logic [TICK_W-1:0] min_stamp_reg;

    // Result register
    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [MAC_W-1:0]  m_mac_out_reg;

    logic              ent_valid;
    logic              ent_match;
    logic              ent_older;
    logic [IDX_W-1:0]  victim;
    logic              do_learn;
    logic              lookup_hit;

    assign ent_valid  = valid_reg[eval_idx_reg];
    assign ent_match  = ent_valid && (rd_ip_reg == key_ip_reg);
    assign ent_older  = ent_valid && (!min_seen_reg || (rd_stamp_reg < min_stamp_reg));
    assign victim     = match_reg ? match_idx_reg : (free_reg ? free_idx_reg : min_idx_reg);
    assign do_learn   = cmd.commit && (func_reg == FUNC_LEARN);
    assign lookup_hit = match_reg && (age_reg <= {{(TICK_W-TTL_W){1'b0}}, ttl_reg});

    assign sts.scan_last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.out_busy  = m_valid_reg && !m_ready;

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_mac_out = m_mac_out_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg      <= TTL_RESET;
            tick_reg     <= '0;
            valid_reg    <= '0;
            idx_reg      <= '0;
            eval_reg     <= 1'b0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
            min_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ttl_reg <= cfg_wr_data;
            end
            eval_reg <= cmd.issue;
            if (cmd.load) begin
                tick_reg     <= tick_reg + TICK_W'(1);
                idx_reg      <= '0;
                match_reg    <= 1'b0;
                free_reg     <= 1'b0;
                min_seen_reg <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (eval_reg) begin
                    if (ent_match && !match_reg) begin
                        match_reg <= 1'b1;
                    end
                    if (!ent_valid && !free_reg) begin
                        free_reg <= 1'b1;
                    end
                    if (ent_older) begin
                        min_seen_reg <= 1'b1;
                    end
                end
            end
            if (do_learn) begin
                valid_reg[victim] <= 1'b1;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= s_func;
            key_ip_reg  <= s_ip_addr;
            key_mac_reg <= s_mac_in;
        end
        eval_idx_reg <= idx_reg;
        if (eval_reg) begin
            if (ent_match && !match_reg) begin
                match_idx_reg <= eval_idx_reg;
                match_mac_reg <= rd_mac_reg;
                age_reg       <= tick_reg - rd_stamp_reg;
            end
            if (!ent_valid && !free_reg) begin
                free_idx_reg <= eval_idx_reg;
            end
            // strict compare keeps the lowest index on equal stamps
            if (ent_older) begin
                min_idx_reg   <= eval_idx_reg;
                min_stamp_reg <= rd_stamp_reg;
            end
        end
        if (cmd.commit) begin
            if (func_reg == FUNC_LEARN) begin
                m_hit_reg     <= match_reg;
                m_mac_out_reg <= '0;
            end else begin
                m_hit_reg     <= lookup_hit;
                m_mac_out_reg <= lookup_hit ? match_mac_reg : '0;
            end
        end
    end

    // Table memories: one read port for the scan, one write port for the commit
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_ip_reg    <= ip_mem[idx_reg];
            rd_mac_reg   <= mac_mem[idx_reg];
            rd_stamp_reg <= stamp_mem[idx_reg];
        end
        if (do_learn) begin
            ip_mem[victim]    <= key_ip_reg;
            mac_mem[victim]   <= key_mac_reg;
            stamp_mem[victim] <= tick_reg;
        end
    end

endmodule

FILE: rtl/arp_cache_lru_ttl.sv
// ARP cache: ENTRIES IPv4-to-MAC bindings with LRU replacement and an age limit.
// s_func 0 learns s_ip_addr -> s_mac_in (updates a matching entry, else fills the lowest
// free slot, else evicts the oldest stamp); s_func 1 looks s_ip_addr up and hits when a
// valid entry matches and is no older than ttl_ticks (written on cfg_wr_en/cfg_wr_data,
// reset 300000). Every word advances a 64-bit operation tick; lookups never refresh
// stamps. One result word per input word. The table is scanned one entry per cycle
// through a single memory read port, then a drain state and a resolve state follow;
// the result is loaded into the output register in the resolve state, and a new word is
// taken only in the idle state, once the previous word has been resolved.
// A finished result waits in the output register while the next word is accepted; the
// next word's resolve cycle stalls until that register is taken.
module arp_cache_lru_ttl import arpc_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_func,
    input  logic [IP_W-1:0]  s_ip_addr,
    input  logic [MAC_W-1:0] s_mac_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_hit,
    output logic [MAC_W-1:0] m_mac_out,
    input  logic             cfg_wr_en,
    input  logic [TTL_W-1:0] cfg_wr_data
);

    arpc_cmd_t cmd;
    arpc_sts_t sts;

    arpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    arpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_func      (s_func),
        .s_ip_addr   (s_ip_addr),
        .s_mac_in    (s_mac_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_mac_out   (m_mac_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: rtl/arpc_checker.sv
`include "arp_cache_lru_ttl_assert.svh"

module arpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic [31:0] s_ip_addr,
    input logic [47:0] s_mac_in,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [47:0] m_mac_out,
    input logic        cfg_wr_en,
    input logic [31:0] cfg_wr_data
);

    // one word at a time: no accept right after an accept
    `ARPC_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "accept while busy")

    // a miss never carries a MAC; a learn that hits is not checked here
    `ARPC_ASSERT_NOW(a_miss_zero_mac, m_valid && !m_hit, m_mac_out == 48'd0, "MAC on miss")

    `ARPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped")

    `ARPC_ASSERT_NEXT(a_out_stable, m_valid && !m_ready,
        $stable(m_hit) && $stable(m_mac_out), "result changed while stalled")

endmodule

bind arp_cache_lru_ttl arpc_checker u_arpc_checker (.*);
